[sv/cpf_pkg.sv]
// Package: item types, burst type and framing constants of the command packet framer.
`default_nettype none
package cpf_pkg;

	localparam logic [7:0] HDR_BYTE       = 8'h55;
	localparam logic [7:0] FTR_BYTE       = 8'hAA;
	localparam logic [7:0] CONNECT_CODE   = 8'hDC;
	localparam logic [7:0] CONNECT_PREFIX = 8'h03;
	localparam int unsigned BURST_MAX     = 8;
	localparam int unsigned CNT_W         = $clog2(BURST_MAX + 1);

	typedef enum logic {
		KIND_START   = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] command;
		logic [7:0] length;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       last;
		logic       error;
	} out_item_t;

	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      footer;
		logic                      error;
	} burst_t;

endpackage
`default_nettype wire

[sv/cpf_builder.sv]
// Frame state and the combinational burst builder for one input item.
`default_nettype none
module cpf_builder
	import cpf_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 249
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     fire,
	input  wire in_item_t item,
	output burst_t        burst
);

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

	logic       frame_open_q;
	logic [7:0] bytes_left_q;
	logic [7:0] running_xor_q;

	logic       nxt_open;
	logic [7:0] nxt_left;
	logic [7:0] nxt_xor;

	logic [6:0][7:0] hdr;
	logic [7:0]      seed;
	logic [7:0]      chk_pay;
	logic            pre;

	always_comb begin
		seed    = item.command ^ item.length;
		chk_pay = running_xor_q ^ item.data_byte;
		pre     = (item.command == CONNECT_CODE);
		hdr[0]  = HDR_BYTE;
		hdr[1]  = HDR_BYTE;
		hdr[2]  = item.command;
		hdr[3]  = item.length;
		hdr[4]  = seed;
		hdr[5]  = FTR_BYTE;
		hdr[6]  = FTR_BYTE;

		burst    = '0;
		nxt_open = frame_open_q;
		nxt_left = bytes_left_q;
		nxt_xor  = running_xor_q;

		if (item.kind == KIND_START) begin
			if (frame_open_q || (item.length > MaxLen)) begin
				burst.count = CNT_W'(1);
				burst.error = 1'b1;
			end else begin
				nxt_xor = seed;
				if (pre) begin
					burst.bytes[0] = CONNECT_PREFIX;
					for (int i = 0; i < 7; i++) burst.bytes[i+1] = hdr[i];
				end else begin
					for (int i = 0; i < 7; i++) burst.bytes[i] = hdr[i];
				end
				if (item.length == 8'd0) begin
					burst.count  = CNT_W'(pre ? 8 : 7);
					burst.footer = 1'b1;
				end else begin
					burst.count = CNT_W'(pre ? 5 : 4);
					nxt_open    = 1'b1;
					nxt_left    = item.length;
				end
			end
		end else begin
			if (!frame_open_q) begin
				burst.count = CNT_W'(1);
				burst.error = 1'b1;
			end else begin
				burst.bytes[0] = item.data_byte;
				burst.bytes[1] = chk_pay;
				burst.bytes[2] = FTR_BYTE;
				burst.bytes[3] = FTR_BYTE;
				nxt_xor        = chk_pay;
				nxt_left       = bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					burst.count  = CNT_W'(4);
					burst.footer = 1'b1;
					nxt_open     = 1'b0;
				end else begin
					burst.count = CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q  <= 1'b0;
			bytes_left_q  <= 8'd0;
			running_xor_q <= 8'd0;
		end else if (fire) begin
			frame_open_q  <= nxt_open;
			bytes_left_q  <= nxt_left;
			running_xor_q <= nxt_xor;
		end
	end

endmodule
`default_nettype wire

[sv/cpf_out_seq.sv]
// Result register: holds one burst; shifts out one item per cycle while ready.
`default_nettype none
module cpf_out_seq
	import cpf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire burst_t    burst,
	output logic           can_load,
	output logic           valid,
	input  wire logic      ready,
	output out_item_t      item
);

	logic [BURST_MAX-1:0][7:0] bytes_q;
	logic [CNT_W-1:0]          rem_q;
	logic                      footer_q;
	logic                      error_q;
	logic                      valid_q;
	logic                      is_last;

	assign is_last  = (rem_q == CNT_W'(1));
	assign can_load = !valid_q || (ready && is_last);
	assign valid    = valid_q;

	always_comb begin
		item.out_byte  = bytes_q[0];
		item.last      = is_last;
		item.frame_end = is_last && footer_q;
		item.error     = error_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			rem_q   <= burst.count;
		end else if (valid_q && ready) begin
			rem_q <= rem_q - CNT_W'(1);
			if (is_last) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= burst.bytes;
			footer_q <= burst.footer;
			error_q  <= burst.error;
		end else if (valid_q && ready) begin
			for (int i = 0; i < BURST_MAX - 1; i++) bytes_q[i] <= bytes_q[i+1];
			bytes_q[BURST_MAX-1] <= 8'd0;
		end
	end

endmodule
`default_nettype wire

[sv/command_packet_framer_top.sv]
// Top level of the command packet framer.
//
// Input channel (in_valid/in_ready/in_item): start items carry command and
// length, payload items carry one data byte. Output channel
// (out_valid/out_ready/out_item) delivers the framed byte stream, one byte
// per item, with last marking the final byte caused by an input item.
// Each accepted input item is turned into a burst of 1 to 8 bytes in the
// same cycle and lands in the result register; the first byte is visible
// in the cycle after acceptance. The result register drains one byte per
// cycle while out_ready is high, and a new input item is accepted in the
// cycle the last byte of the current burst is taken, so a payload byte in
// mid-frame sustains one item per cycle. A start item yields 4 to 8 bytes,
// a frame-closing payload byte 4, an error item 1. Throughput is set by the
// single result register. When the receiver stalls, the current byte holds
// and in_ready stays low until the burst's last byte is taken. Reset clears
// the frame state and the result register; no item is pending afterwards.
`default_nettype none
module command_packet_framer_top
	import cpf_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 249
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	burst_t burst;
	logic   fire;

	assign fire = in_valid && in_ready;

	cpf_builder #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_builder (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (in_item),
		.burst (burst)
	);

	cpf_out_seq u_out_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire),
		.burst   (burst),
		.can_load(in_ready),
		.valid   (out_valid),
		.ready   (out_ready),
		.item    (out_item)
	);

endmodule
`default_nettype wire

[sv/cpf_checker.sv]
// Port-level checker for the command packet framer and its bind.
`default_nettype none
module cpf_checker
	import cpf_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.error |-> out_item.last && !out_item.frame_end
			&& (out_item.out_byte == 8'd0))
		else $error("error item is not a lone zero item");

	a_end_footer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_end |-> out_item.last && (out_item.out_byte == FTR_BYTE))
		else $error("frame end is not a final footer byte");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no output");

endmodule

bind command_packet_framer_top cpf_checker u_cpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
`default_nettype wire
